// ===== src/sv39_page_table_walk_map_macros.svh =====
// Assertion macros used by the checker of the page table walker.
`ifndef SV39_PAGE_TABLE_WALK_MAP_MACROS_SVH
`define SV39_PAGE_TABLE_WALK_MAP_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define SV39PTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SV39PTW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sv39ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Types, field widths and codes of the Sv39 page table walker.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

    localparam int unsigned LEVEL_BITS    = 9;
    localparam int unsigned FRAME_ENTRIES = 512;
    localparam int unsigned PPN_SHIFT     = 10;
    localparam int unsigned PPN_W         = 44;
    localparam int unsigned VPN_W         = 27;
    localparam int unsigned PERM_W        = 4;
    localparam int unsigned ENTRY_W       = 54;

    typedef logic [VPN_W-1:0]      vpn_t;
    typedef logic [PPN_W-1:0]      ppn_t;
    typedef logic [PERM_W-1:0]     perm_t;
    typedef logic [ENTRY_W-1:0]    entry_t;
    typedef logic [LEVEL_BITS-1:0] idx_t;
    typedef logic [1:0]            status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_NO_FRAME = 2'd1;
    localparam status_t STATUS_MISSING  = 2'd2;

    localparam logic REQ_MAP    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

endpackage

// ===== src/sv39_page_table_walk_map.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_walk_map
// Three-level Sv39 page table walker with an internal table store and a
// bump allocator for intermediate table frames.
// ----------------------------------------------------------------------------
// After reset the block sweeps its table store to zero, one entry per cycle,
// and takes no input beat until the sweep is done. Pool base writes on
// cfg_we/cfg_wdata are taken at any time. Frame 0 of the store is the root
// table. A map beat (req_type 0) walks levels 2 and 1 and links a fresh
// frame wherever an intermediate entry is invalid. It then writes the leaf
// entry {phys_page, perm_bits, valid}. A lookup beat (req_type 1) walks
// without allocating and returns the leaf entry it finds. Every input beat
// gives exactly one result beat. The store has one read and one write port,
// and each walk step needs the previous read. An item that allocates nothing
// passes from acceptance to the result register through the accepting
// cycle, two walk steps, the leaf step and the result load; an item that
// stops at an intermediate level skips the remaining walk and leaf steps.
// Each fresh frame adds a clear of all its entries, because a moved pool
// base can leave stale entries in a frame not yet handed out, a write of
// the link and a read of the next level from the new frame. A result still
// waiting downstream stalls the next item in its final step only. The link
// offset subtract and the new-link address add share one 44-bit adder.
// Frames are never returned to the pool; once POOL_FRAMES frames are in use
// further map beats that need a frame report "no free frame".

module sv39_page_table_walk_map #(
    parameter int unsigned POOL_FRAMES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  sv39ptw_pkg::ppn_t    cfg_wdata,
    // request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  sv39ptw_pkg::vpn_t    virt_page,
    input  sv39ptw_pkg::ppn_t    phys_page,
    input  sv39ptw_pkg::perm_t   perm_bits,
    input  logic                 last_of_range,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output sv39ptw_pkg::status_t status_code,
    output sv39ptw_pkg::entry_t  leaf_entry,
    output logic                 range_done
);

    import sv39ptw_pkg::*;

    localparam int unsigned FRAME_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
    localparam int unsigned ADDR_W  = FRAME_W + LEVEL_BITS;
    localparam int unsigned DEPTH   = POOL_FRAMES * FRAME_ENTRIES;
    localparam int unsigned NF_W    = $clog2(POOL_FRAMES + 1);

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_LEAF  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_FILL  = 3'd5;
    localparam logic [2:0] ST_LINK  = 3'd6;
    localparam logic [2:0] ST_READ  = 3'd7;

    // table store: one write port, one registered read port
    entry_t mem [DEPTH];

    logic [2:0]        state_reg,   state_next;
    logic [ADDR_W-1:0] clr_reg,     clr_next;
    logic [NF_W-1:0]   nf_reg,      nf_next;
    ppn_t              base_reg,    base_next;
    logic              out_vld_reg, out_vld_next;

    // item payload, held for the length of the walk
    logic              lookup_reg,  lookup_next;
    vpn_t              vpn_reg,     vpn_next;
    ppn_t              ppn_reg,     ppn_next;
    perm_t             perm_reg,    perm_next;
    logic              last_reg,    last_next;
    logic              lvl2_reg,    lvl2_next;
    logic [ADDR_W-1:0] slot_reg,    slot_next;
    status_t           res_st_reg,  res_st_next;
    entry_t            res_leaf_reg, res_leaf_next;

    // output register
    status_t           out_st_reg,   out_st_next;
    entry_t            out_leaf_reg, out_leaf_next;
    logic              out_done_reg, out_done_next;

    entry_t            rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    // shared adder: entry page minus pool base, or pool base plus free frame
    logic              entry_vld;
    ppn_t              entry_ppn;
    logic              alu_sub;
    ppn_t              alu_a;
    ppn_t              alu_b;
    ppn_t              alu_res;
    logic              link_in_pool;
    logic              pool_full;
    idx_t              idx_next;
    entry_t            link_entry;
    entry_t            built_leaf;
    logic              step_go;
    logic [FRAME_W-1:0] frame_n;

    assign entry_vld  = rd_data_reg[0];
    assign entry_ppn  = rd_data_reg[ENTRY_W-1:PPN_SHIFT];
    assign alu_sub    = (state_reg == ST_WALK);
    assign alu_a      = alu_sub ? entry_ppn : base_reg;
    assign alu_b      = alu_sub ? base_reg  : PPN_W'(nf_reg);
    assign alu_res    = alu_a + (alu_b ^ {PPN_W{alu_sub}}) + PPN_W'(alu_sub);

    assign link_in_pool = (alu_res < PPN_W'(POOL_FRAMES));
    assign pool_full    = (nf_reg >= NF_W'(POOL_FRAMES));
    assign idx_next     = lvl2_reg ? vpn_reg[LEVEL_BITS +: LEVEL_BITS]
                                   : vpn_reg[0 +: LEVEL_BITS];
    assign link_entry   = {alu_res, {(PPN_SHIFT-1){1'b0}}, 1'b1};
    assign built_leaf   = {ppn_reg, {(PPN_SHIFT-1-PERM_W){1'b0}}, perm_reg, 1'b1};

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_vld_reg;
    assign status_code = out_st_reg;
    assign leaf_entry  = out_leaf_reg;
    assign range_done  = out_done_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        nf_next       = nf_reg;
        base_next     = cfg_we ? cfg_wdata : base_reg;
        out_vld_next  = out_vld_reg;
        lookup_next   = lookup_reg;
        vpn_next      = vpn_reg;
        ppn_next      = ppn_reg;
        perm_next     = perm_reg;
        last_next     = last_reg;
        lvl2_next     = lvl2_reg;
        slot_next     = slot_reg;
        res_st_next   = res_st_reg;
        res_leaf_next = res_leaf_reg;
        out_st_next   = out_st_reg;
        out_leaf_next = out_leaf_reg;
        out_done_next = out_done_reg;
        rd_addr       = slot_reg;
        mem_we        = 1'b0;
        mem_waddr     = slot_reg;
        mem_wdata     = built_leaf;
        step_go       = 1'b0;
        frame_n       = '0;

        // drop the result once the far side takes it
        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // read the root entry for level 2 as the beat is taken
                rd_addr = {FRAME_W'(0), virt_page[2*LEVEL_BITS +: LEVEL_BITS]};
                if (in_valid)
                begin
                    lookup_next = (req_type == REQ_LOOKUP);
                    vpn_next    = virt_page;
                    ppn_next    = phys_page;
                    perm_next   = perm_bits;
                    last_next   = last_of_range;
                    lvl2_next   = 1'b1;
                    slot_next   = rd_addr;
                    state_next  = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (entry_vld)
                begin
                    if (link_in_pool)
                    begin
                        frame_n = alu_res[FRAME_W-1:0];
                        step_go = 1'b1;
                    end
                    else
                    begin
                        res_st_next   = STATUS_MISSING;
                        res_leaf_next = '0;
                        state_next    = ST_DONE;
                    end
                end
                else if (lookup_reg)
                begin
                    res_st_next   = STATUS_MISSING;
                    res_leaf_next = '0;
                    state_next    = ST_DONE;
                end
                else if (pool_full)
                begin
                    res_st_next   = STATUS_NO_FRAME;
                    res_leaf_next = '0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    // clear the next free frame before it is linked
                    clr_next   = {nf_reg[FRAME_W-1:0], idx_t'(0)};
                    state_next = ST_FILL;
                end

                if (step_go)
                begin
                    rd_addr   = {frame_n, idx_next};
                    slot_next = rd_addr;
                    lvl2_next = 1'b0;
                    if (!lvl2_reg)
                    begin
                        state_next = ST_LEAF;
                    end
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg[LEVEL_BITS-1:0] == {LEVEL_BITS{1'b1}})
                begin
                    state_next = ST_LINK;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end

            ST_LINK:
            begin
                // write the link after the clear, then advance to the new frame
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = link_entry;
                nf_next   = nf_reg + NF_W'(1);
                frame_n   = nf_reg[FRAME_W-1:0];
                slot_next = {frame_n, idx_next};
                state_next = ST_READ;
            end

            ST_READ:
            begin
                // read the next level once the link write has landed
                rd_addr   = slot_reg;
                lvl2_next = 1'b0;
                if (lvl2_reg)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_LEAF;
                end
            end

            ST_LEAF:
            begin
                res_st_next = STATUS_OK;
                if (lookup_reg)
                begin
                    res_leaf_next = rd_data_reg;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = slot_reg;
                    mem_wdata     = built_leaf;
                    res_leaf_next = built_leaf;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_vld_reg || out_ready)
                begin
                    out_vld_next  = 1'b1;
                    out_st_next   = res_st_reg;
                    out_leaf_next = res_leaf_reg;
                    out_done_next = last_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            nf_reg      <= NF_W'(1);
            base_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            nf_reg      <= nf_next;
            base_reg    <= base_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        lookup_reg   <= lookup_next;
        vpn_reg      <= vpn_next;
        ppn_reg      <= ppn_next;
        perm_reg     <= perm_next;
        last_reg     <= last_next;
        lvl2_reg     <= lvl2_next;
        slot_reg     <= slot_next;
        res_st_reg   <= res_st_next;
        res_leaf_reg <= res_leaf_next;
        out_st_reg   <= out_st_next;
        out_leaf_reg <= out_leaf_next;
        out_done_reg <= out_done_next;
    end

    // table store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== src/sv39ptw_checker.sv =====
// ----------------------------------------------------------------------------
// sv39ptw_checker
// Port-level checks on the page table walker, bound to its top level.
// ----------------------------------------------------------------------------
`include "sv39_page_table_walk_map_macros.svh"

module sv39ptw_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input sv39ptw_pkg::status_t status_code,
    input sv39ptw_pkg::entry_t  leaf_entry
);

    import sv39ptw_pkg::*;

    // only the three defined codes ever leave the block
    `SV39PTW_ASSERT_ALWAYS(a_status_legal, out_valid |-> (status_code == STATUS_OK || status_code == STATUS_NO_FRAME || status_code == STATUS_MISSING), "illegal status code")

    // a failed walk carries an empty entry
    `SV39PTW_ASSERT(a_fail_zero, (out_valid && status_code != STATUS_OK) |-> (leaf_entry == '0), "failed walk with non-zero entry")

    // a non-zero result entry has its valid bit set
    `SV39PTW_ASSERT(a_leaf_valid, (out_valid && leaf_entry != '0) |-> leaf_entry[0], "non-zero entry without valid bit")

    // one item at a time: busy right after a beat is taken
    `SV39PTW_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready straight after accept")

    // a stalled result holds
    `SV39PTW_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(leaf_entry) && $stable(status_code)), "stalled result changed")

endmodule

bind sv39_page_table_walk_map sv39ptw_checker u_sv39ptw_checker (.*);

// ===== tb/sv39_page_table_walk_map_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_page_table_walk_map_tb
// Self-checking bench for the Sv39 page table walker. A directed table covers
// the extremes and the missing-table path. Five random phases follow, each
// after a fresh pool base write. A mirror of the table store predicts every
// result beat without a typed expectation, and both channels idle at random.
// ----------------------------------------------------------------------------
module sv39_page_table_walk_map_tb;

    import sv39ptw_pkg::*;

    localparam int unsigned POOL_FRAMES  = 64;
    localparam int          DIR_ROWS     = 16;
    localparam int          RAND_PHASES  = 5;
    localparam int          PHASE_BEATS  = 130;
    localparam int          SHOWN_FAULTS = 10;
    localparam ppn_t        PPN_MAX      = {PPN_W{1'b1}};

    // One request beat, with an optional hand-typed expectation.
    typedef struct packed {
        logic    rq;
        vpn_t    vpn;
        ppn_t    ppn;
        perm_t   perm;
        logic    last;
        logic    typed;
        status_t st;
        entry_t  leaf;
    } stim_row_t;

    typedef struct packed {
        status_t st;
        entry_t  leaf;
        logic    done;
    } walk_result_t;

    logic    clk           = 1'b0;
    logic    rst_n         = 1'b0;
    logic    cfg_we        = 1'b0;
    ppn_t    cfg_wdata     = '0;
    logic    in_valid      = 1'b0;
    logic    in_ready;
    logic    req_type      = REQ_MAP;
    vpn_t    virt_page     = '0;
    ppn_t    phys_page     = '0;
    perm_t   perm_bits     = '0;
    logic    last_of_range = 1'b0;
    logic    out_valid;
    logic    out_ready     = 1'b0;
    status_t status_code;
    entry_t  leaf_entry;
    logic    range_done;

    // Mirror of the block's state: table store, bump allocator, pool base.
    bit [63:0]   table_mirror [POOL_FRAMES * FRAME_ENTRIES];
    int unsigned frames_issued = 1;
    ppn_t        pool_base     = '0;

    walk_result_t awaited_results [$];
    vpn_t         mapped_pages [$];
    int           fault_count = 0;
    logic         quiet_phase = 1'b0;
    int           sink_stall  = 0;
    int           sink_roll;
    idx_t         hot_l2 [4];
    idx_t         hot_l1 [4];

    // Rows with typed expectations are read straight off the Sv39 rules:
    // untouched root, first mappings, all-ones leaf, missing tables.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{REQ_LOOKUP, 27'h0000000, 44'h0,           4'h0, 1'b0,
          1'b1, STATUS_MISSING, 54'h0},
        '{REQ_LOOKUP, 27'h7FFFFFF, 44'h0,           4'h0, 1'b1,
          1'b1, STATUS_MISSING, 54'h0},
        '{REQ_MAP,    27'h0000000, 44'h0,           4'h0, 1'b0,
          1'b1, STATUS_OK,      54'h1},
        '{REQ_LOOKUP, 27'h0000000, 44'h0,           4'h0, 1'b0,
          1'b1, STATUS_OK,      54'h1},
        '{REQ_LOOKUP, 27'h0000001, 44'h0,           4'h0, 1'b1,
          1'b1, STATUS_OK,      54'h0},
        '{REQ_MAP,    27'h7FFFFFF, PPN_MAX,         4'hF, 1'b1,
          1'b1, STATUS_OK,      54'h3FFFFFFFFFFC1F},
        '{REQ_LOOKUP, 27'h7FFFFFF, 44'h0,           4'h0, 1'b0,
          1'b1, STATUS_OK,      54'h3FFFFFFFFFFC1F},
        '{REQ_LOOKUP, 27'h0000E00, 44'h0,           4'h0, 1'b0,
          1'b1, STATUS_MISSING, 54'h0},
        '{REQ_MAP,    27'h0000E00, 44'h123456789AB, 4'h1, 1'b0,
          1'b0, STATUS_OK,      54'h0},
        '{REQ_MAP,    27'h0000000, 44'hA5A5A5A5A5A, 4'h2, 1'b0,
          1'b0, STATUS_OK,      54'h0},
        '{REQ_LOOKUP, 27'h0000000, 44'h0,           4'h0, 1'b1,
          1'b0, STATUS_OK,      54'h0},
        '{REQ_MAP,    27'h00001FF, 44'h5A5A5A5A5A5, 4'h4, 1'b1,
          1'b0, STATUS_OK,      54'h0},
        '{REQ_MAP,    27'h7FC0000, 44'h00000000001, 4'h8, 1'b0,
          1'b0, STATUS_OK,      54'h0},
        '{REQ_LOOKUP, 27'h7FC0000, 44'h0,           4'h0, 1'b0,
          1'b0, STATUS_OK,      54'h0},
        '{REQ_LOOKUP, 27'h003FE00, 44'h0,           4'h0, 1'b1,
          1'b1, STATUS_MISSING, 54'h0},
        '{REQ_LOOKUP, 27'h00001FF, PPN_MAX,         4'hF, 1'b0,
          1'b0, STATUS_OK,      54'h0}
    };

    sv39_page_table_walk_map #(
        .POOL_FRAMES(POOL_FRAMES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .virt_page    (virt_page),
        .phys_page    (phys_page),
        .perm_bits    (perm_bits),
        .last_of_range(last_of_range),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status_code  (status_code),
        .leaf_entry   (leaf_entry),
        .range_done   (range_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Walk levels 2 and 1 in the mirror, allocating frames for a map beat,
    // then write or read the leaf slot. Mirrors every side effect.
    function automatic walk_result_t walk_and_map(input stim_row_t beat);
        walk_result_t res;
        int unsigned  frame;
        int unsigned  slot;
        ppn_t         offset;
        bit [63:0]    pte;
        bit           halted;
        res    = '{st: STATUS_OK, leaf: '0, done: beat.last};
        frame  = 0;
        halted = 1'b0;
        for (int lvl = 2; lvl > 0; lvl--)
        begin
            if (!halted)
            begin
                slot = frame * FRAME_ENTRIES + beat.vpn[lvl * LEVEL_BITS +: LEVEL_BITS];
                pte  = table_mirror[slot];
                if (pte[0])
                begin
                    // A link is only usable if it lands inside the pool as it
                    // stands now; a moved base can push it out.
                    offset = ppn_t'(pte[PPN_SHIFT +: PPN_W]) - pool_base;
                    if (offset >= POOL_FRAMES)
                    begin
                        res.st = STATUS_MISSING;
                        halted = 1'b1;
                    end
                    else
                        frame = int'(offset);
                end
                else if (beat.rq == REQ_LOOKUP)
                begin
                    res.st = STATUS_MISSING;
                    halted = 1'b1;
                end
                else if (frames_issued >= POOL_FRAMES)
                begin
                    res.st = STATUS_NO_FRAME;
                    halted = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < FRAME_ENTRIES; k++)
                        table_mirror[frames_issued * FRAME_ENTRIES + k] = '0;
                    table_mirror[slot] = {10'd0, ppn_t'(pool_base + frames_issued),
                                          9'd0, 1'b1};
                    frame = frames_issued;
                    frames_issued++;
                end
            end
        end
        if (!halted)
        begin
            slot = frame * FRAME_ENTRIES + beat.vpn[LEVEL_BITS-1:0];
            if (beat.rq == REQ_LOOKUP)
                res.leaf = entry_t'(table_mirror[slot]);
            else
            begin
                res.leaf           = {beat.ppn, 5'd0, beat.perm, 1'b1};
                table_mirror[slot] = 64'(res.leaf);
            end
        end
        return res;
    endfunction

    // Most gaps are nil, some short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ppn_t pick_ppn();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return PPN_MAX;
        return ppn_t'({$urandom, $urandom});
    endfunction

    // Mostly well-formed beats over a small set of hot table slots, so that
    // tables get reused and lookups find leaves; a few beats scatter widely
    // and drain the frame pool.
    function automatic stim_row_t random_beat();
        stim_row_t beat;
        beat       = '0;
        beat.rq    = ($urandom_range(0, 99) < 40) ? REQ_LOOKUP : REQ_MAP;
        beat.ppn   = pick_ppn();
        beat.perm  = perm_t'($urandom_range(0, 15));
        beat.last  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 8)
            beat.vpn = vpn_t'($urandom);
        else if (beat.rq == REQ_LOOKUP && mapped_pages.size() != 0
                 && $urandom_range(0, 99) < 70)
            beat.vpn = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
        else
            beat.vpn = {hot_l2[$urandom_range(0, 3)], hot_l1[$urandom_range(0, 3)],
                        idx_t'($urandom)};
        return beat;
    endfunction

    // Drive one beat after a random gap and hold it until accepted, then
    // log what the mirror says must come back.
    task automatic send_beat(input stim_row_t beat);
        walk_result_t predicted;
        int           gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= beat.rq;
        virt_page     <= beat.vpn;
        phys_page     <= beat.ppn;
        perm_bits     <= beat.perm;
        last_of_range <= beat.last;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = walk_and_map(beat);
        if (beat.typed)
            awaited_results.push_back('{st: beat.st, leaf: beat.leaf, done: beat.last});
        else
            awaited_results.push_back(predicted);
        if (beat.rq == REQ_MAP)
        begin
            mapped_pages.push_back(beat.vpn);
            if (mapped_pages.size() > 64)
                void'(mapped_pages.pop_front());
        end
    endtask

    // Drop valid and hold off until every result beat is back.
    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_fault(input string why, input walk_result_t want,
                              input walk_result_t got);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
            $display("%0t fault (%s): want st=%0d leaf=%h done=%b, got st=%0d leaf=%h done=%b",
                     $realtime, why, want.st, want.leaf, want.done,
                     got.st, got.leaf, got.done);
    endtask

    // Result side: random back-pressure, with a calm phase that never stalls.
    always @(posedge clk)
    begin
        if (quiet_phase)
            out_ready <= 1'b1;
        else if (sink_stall != 0)
        begin
            out_ready  <= 1'b0;
            sink_stall = sink_stall - 1;
        end
        else
        begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 70)
                out_ready <= 1'b1;
            else
            begin
                out_ready  <= 1'b0;
                sink_stall = (sink_roll < 95) ? $urandom_range(0, 2)
                                              : $urandom_range(9, 29);
            end
        end
    end

    // Compare every result beat with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        walk_result_t got;
        walk_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{st: status_code, leaf: leaf_entry, done: range_done};
            if (awaited_results.size() == 0)
                note_fault("unexpected beat", '0, got);
            else
            begin
                want = awaited_results.pop_front();
                if (want.st !== got.st)
                    note_fault("status_code", want, got);
                else if (want.leaf !== got.leaf)
                    note_fault("leaf_entry", want, got);
                else if (want.done !== got.done)
                    note_fault("range_done", want, got);
            end
        end
    end

    // Watchdog: bounds the whole run, the store sweep after reset included.
    initial
    begin
        #(6_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        ppn_t phase_base;
        hot_l2[0] = '0;
        hot_l2[1] = '1;
        hot_l2[2] = idx_t'($urandom);
        hot_l2[3] = idx_t'($urandom);
        hot_l1[0] = '0;
        hot_l1[1] = '1;
        hot_l1[2] = idx_t'($urandom);
        hot_l1[3] = idx_t'($urandom);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset pool base. The block ignores input
        // beats until its store sweep is done, so the first send just waits.
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i]);

        // Random phases, each under a freshly written pool base: the two extremes
        // (zero twice), a random one, and a base of one to alias old links onto other frames.
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:       phase_base = PPN_MAX;
                2:       phase_base = ppn_t'({$urandom, $urandom});
                3:       phase_base = ppn_t'(1);
                default: phase_base = '0;
            endcase
            cfg_we      <= 1'b1;
            cfg_wdata   <= phase_base;
            quiet_phase <= (phase == 3);
            @(posedge clk);
            cfg_we    <= 1'b0;
            pool_base = phase_base;
            for (int n = 0; n < PHASE_BEATS; n++)
                send_beat(random_beat());
        end

        drain();
        repeat (10) @(posedge clk);
        if (fault_count == 0 && awaited_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/sv39ptw_pkg.sv
src/sv39_page_table_walk_map.sv
src/sv39ptw_checker.sv
tb/sv39_page_table_walk_map_tb.sv
